[hw/rtl/grad_unscale_and_loss_scale_update_core_macros.svh]
// Assertion helpers
`ifndef GRAD_UNSCALE_AND_LOSS_SCALE_UPDATE_CORE_MACROS_SVH
`define GRAD_UNSCALE_AND_LOSS_SCALE_UPDATE_CORE_MACROS_SVH
`define GUL_ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("%m");
`define GUL_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("%m");
`endif

[hw/rtl/gul_pkg.sv]
`timescale 1ns / 1ps
package gul_pkg;
	localparam logic [1:0] CMD_UNSCALE = 2'd0;
	localparam logic [1:0] CMD_UPDATE  = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;
	localparam logic [2:0] REG_INV   = 3'd0;
	localparam logic [2:0] REG_GROW  = 3'd1;
	localparam logic [2:0] REG_BACK  = 3'd2;
	localparam logic [2:0] REG_STEPS = 3'd3;
	localparam logic [2:0] REG_START = 3'd4;
	localparam logic [31:0] FP_ONE = 32'h3F80_0000;
	localparam logic [31:0] FP_DNAN = 32'h7FC0_0000;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] value;
	} in_word_t;

	typedef struct packed {
		logic [31:0] result_value;
		logic        nonfinite_seen;
		logic [31:0] scale_now;
		logic [15:0] clean_count;
	} out_word_t;

	// classified word between front and back
	typedef struct packed {
		logic        is_unscale;
		logic        pass;
		logic [31:0] a;
		logic [31:0] b;
		logic        nonfinite_seen;
		logic [31:0] scale_now;
		logic [15:0] clean_count;
	} job_t;
endpackage

[hw/rtl/gul_stream_if.sv]
`timescale 1ns / 1ps
interface gul_stream_if #(parameter int W = 34);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/grad_unscale_and_loss_scale_update_core.sv]
`timescale 1ns / 1ps
// Path: a word accepted on in_ch is written to the queue, then to the output register
// once the queue head can pop; a stalled out_ch can hold it in the queue.
// Throughput: one word per cycle for every command while the queue is not full; in_ch stalls when it is full.
// Reset: arst_n clears state; registers return to defaults, scale to 32768.0.
`include "grad_unscale_and_loss_scale_update_core_macros.svh"
module grad_unscale_and_loss_scale_update_core (
	input  logic         clk,
	input  logic         arst_n,
	gul_stream_if.sink   in_ch,
	gul_stream_if.sink   cfg,
	gul_stream_if.source out_ch
);
	logic          q_full, q_empty, push;
	gul_pkg::job_t job;

	gul_front u_front (.clk, .arst_n, .in_ch, .cfg, .q_full, .push, .job);
	gul_back u_back (.clk, .arst_n, .push, .job, .q_full, .q_empty, .out_ch);

	`GUL_ASSERT_IMPL(a_nopush_full, clk, arst_n, q_full, !push)
	`GUL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
	`GUL_ASSERT_NEXT(a_out_stable, clk, arst_n, out_ch.valid && !out_ch.ready, $stable(out_ch.data))
	`GUL_ASSERT_NEXT(a_out_after, clk, arst_n, push, !q_empty || out_ch.valid)
endmodule

[hw/rtl/gul_fmul.sv]
`timescale 1ns / 1ps
module gul_fmul (
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] p
);
	logic        sa, sb, sp;
	logic [7:0]  ea, eb;
	logic [22:0] fa, fb;
	logic        anan, bnan, ainf, binf, az, bz;
	logic [23:0] ma, mb;
	logic [47:0] prod, norm;
	logic [5:0]  lz;
	logic signed [10:0] exp0, expn;
	logic [49:0] ext;
	logic [9:0]  sh;
	logic [24:0] mant;
	logic        g, st, rnd;
	logic [24:0] mr;
	logic signed [10:0] ef;
	integer i;

	always_comb begin
		sa = a[31]; sb = b[31]; sp = sa ^ sb;
		ea = a[30:23]; eb = b[30:23]; fa = a[22:0]; fb = b[22:0];
		anan = (ea == 8'hFF) && (fa != 0); bnan = (eb == 8'hFF) && (fb != 0);
		ainf = (ea == 8'hFF) && (fa == 0); binf = (eb == 8'hFF) && (fb == 0);
		az = (ea == 0) && (fa == 0); bz = (eb == 0) && (fb == 0);
		ma = {ea != 0, fa}; mb = {eb != 0, fb};
		prod = ma * mb;
		lz = 6'd0;
		for (i = 0; i < 48; i++) if (prod[i]) lz = 6'(47 - i);
		norm = prod << lz;
		// value of prod = norm * 2^(e-?) ; norm[47] is leading one
		exp0 = 11'(signed'({3'b0, (ea == 0) ? 8'd1 : ea})) +
			11'(signed'({3'b0, (eb == 0) ? 8'd1 : eb})) - 11'sd126 - 11'(signed'({5'b0, lz}));
		if (exp0 <= 0) begin
			sh = 10'(1 - exp0);
			expn = 11'sd0;
		end else begin
			sh = 10'd0;
			expn = exp0;
		end
		ext = {norm, 2'b00};
		if (sh > 10'd49) begin
			st = |ext;
			ext = '0;
		end else begin
			st = 1'b0;
			for (i = 0; i < 50; i++) if (i < sh && ext[i]) st = 1'b1;
			ext = ext >> sh;
		end
		mant = {1'b0, ext[49:26]};
		g = ext[25];
		st = st | (|ext[24:0]);
		rnd = g && (st || mant[0]);
		mr = mant + 25'(rnd);
		ef = expn;
		if (mr[24]) begin
			mr = mr >> 1;
			ef = ef + 11'sd1;
		end else if (expn == 0 && mr[23]) begin
			ef = 11'sd1;
		end
		if (anan) p = a | 32'h0040_0000;
		else if (bnan) p = b | 32'h0040_0000;
		else if ((ainf && bz) || (binf && az)) p = gul_pkg::FP_DNAN;
		else if (ainf || binf) p = {sp, 8'hFF, 23'd0};
		else if (az || bz) p = {sp, 31'd0};
		else if (ef >= 11'sd255) p = {sp, 8'hFF, 23'd0};
		else p = {sp, ef[7:0], mr[22:0]};
	end
endmodule

[hw/rtl/gul_front.sv]
`timescale 1ns / 1ps
module gul_front (
	input  logic                clk,
	input  logic                arst_n,
	gul_stream_if.sink          in_ch,
	gul_stream_if.sink          cfg,
	input  logic                q_full,
	output logic                push,
	output gul_pkg::job_t       job
);
	logic [31:0] inv_q, grow_q, back_q, scale_q;
	logic [15:0] steps_q, cnt_q;
	logic        flag_q;
	logic [1:0]  cmd;
	logic [31:0] val;
	logic [15:0] nxt;
	logic [31:0] new_scale, mul_b;
	logic        do_mul, acc;
	logic [2:0]  cidx;

	assign cmd = in_ch.data[33:32];
	assign val = in_ch.data[31:0];
	assign cidx = cfg.data[34:32];
	assign cfg.ready = 1'b1;
	assign in_ch.ready = !q_full;
	assign acc = in_ch.valid && in_ch.ready;
	assign push = acc;
	assign nxt = cnt_q + 16'd1;
	assign do_mul = (cmd == gul_pkg::CMD_UPDATE) && (flag_q || nxt == steps_q);
	assign mul_b = flag_q ? back_q : grow_q;

	gul_fmul u_smul (.a(scale_q), .b(mul_b), .p(new_scale));

	always_comb begin
		job = '0;
		job.a = val;
		job.b = inv_q;
		job.is_unscale = cmd == gul_pkg::CMD_UNSCALE;
		job.pass = inv_q == gul_pkg::FP_ONE;
		job.nonfinite_seen = flag_q;
		job.scale_now = do_mul ? new_scale : scale_q;
		job.clean_count = cnt_q;
		case (cmd)
			gul_pkg::CMD_UNSCALE: job.nonfinite_seen = flag_q | (&val[30:23]);
			gul_pkg::CMD_UPDATE: job.clean_count = (flag_q || nxt == steps_q) ? 16'd0 : nxt;
			gul_pkg::CMD_CLEAR: job.nonfinite_seen = 1'b0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= gul_pkg::FP_ONE;
			grow_q <= 32'h4000_0000;
			back_q <= 32'h3F00_0000;
			steps_q <= 16'd2000;
			scale_q <= 32'h4700_0000;
			cnt_q <= '0;
			flag_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cidx)
					gul_pkg::REG_INV: inv_q <= cfg.data[31:0];
					gul_pkg::REG_GROW: grow_q <= cfg.data[31:0];
					gul_pkg::REG_BACK: back_q <= cfg.data[31:0];
					gul_pkg::REG_STEPS: steps_q <= cfg.data[15:0];
					gul_pkg::REG_START: ;
					default: ;
				endcase
			end
			if (acc) begin
				flag_q <= job.nonfinite_seen;
				cnt_q <= job.clean_count;
				scale_q <= job.scale_now;
			end else if (cfg.valid && cidx == gul_pkg::REG_START) begin
				scale_q <= cfg.data[31:0];
			end
		end
	end
endmodule

[hw/rtl/gul_back.sv]
`timescale 1ns / 1ps
module gul_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gul_pkg::job_t job,
	output logic          q_full,
	output logic          q_empty,
	gul_stream_if.source  out_ch
);
	gul_pkg::job_t q_mem [2];
	logic [1:0] cnt_q;
	logic       wp_q, rp_q;
	gul_pkg::job_t hd;
	logic [31:0] prod;
	logic       pop;
	gul_pkg::out_word_t ow;

	assign q_full = cnt_q == 2'd2;
	assign q_empty = cnt_q == 2'd0;
	assign hd = q_mem[rp_q];
	assign pop = !q_empty && (!out_ch.valid || out_ch.ready);

	gul_fmul u_mul (.a(hd.a), .b(hd.b), .p(prod));

	always_comb begin
		ow.result_value = !hd.is_unscale ? 32'd0 : (hd.pass ? hd.a : prod);
		ow.nonfinite_seen = hd.nonfinite_seen;
		ow.scale_now = hd.scale_now;
		ow.clean_count = hd.clean_count;
	end

	always_ff @(posedge clk) begin
		if (push) q_mem[wp_q] <= job;
		if (pop) out_ch.data <= ow;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			out_ch.valid <= 1'b0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
			if (pop) out_ch.valid <= 1'b1;
			else if (out_ch.ready) out_ch.valid <= 1'b0;
		end
	end
endmodule
